// File: hdl/vpfb_pkg.sv
// Shared constants, types and the color palette of the video port frame buffer.
package vpfb_pkg;

  localparam int unsigned TEXT_COLUMNS_DEF = 80;
  localparam int unsigned TEXT_ROWS_DEF    = 48;
  localparam int unsigned GFX_COLUMNS_DEF  = 320;
  localparam int unsigned GFX_ROWS_DEF     = 240;
  localparam int unsigned STORE_DEPTH_DEF  = 38400;
  localparam int unsigned DIV_WIDTH        = 17;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } vpfb_op_e;

  localparam logic [7:0] PORT_DATA    = 8'h50;
  localparam logic [7:0] PORT_ADDR_LO = 8'h51;
  localparam logic [7:0] PORT_ADDR_HI = 8'h52;
  localparam logic [7:0] PORT_MODE    = 8'h53;

  localparam logic [7:0] MODE_TEXT    = 8'h00;
  localparam logic [7:0] MODE_GFX     = 8'h01;
  localparam logic [7:0] NO_DATA      = 8'hFF;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'h0:    rgb = 24'h000000;
      4'h1:    rgb = 24'h0000c0;
      4'h2:    rgb = 24'h00a000;
      4'h3:    rgb = 24'h00c0c0;
      4'h4:    rgb = 24'ha00000;
      4'h5:    rgb = 24'hc000c0;
      4'h6:    rgb = 24'ha06020;
      4'h7:    rgb = 24'hc0c0c0;
      4'h8:    rgb = 24'h808080;
      4'h9:    rgb = 24'h0000f0;
      4'ha:    rgb = 24'h00f000;
      4'hb:    rgb = 24'h00f0f0;
      4'hc:    rgb = 24'hf00000;
      4'hd:    rgb = 24'hf000f0;
      4'he:    rgb = 24'hf0f000;
      default: rgb = 24'hf0f0f0;
    endcase
    return rgb;
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] a);
    return (a == 16'hFFFF) ? a : a + 16'd1;
  endfunction

endpackage

// File: hdl/vpfb_in_if.sv
// Channel carrying one I/O port access into the frame buffer.
interface vpfb_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] port;
  logic [7:0] value;
  logic       suppress_update;

  modport source (output valid, opcode, port, value, suppress_update, input ready);
  modport sink (input valid, opcode, port, value, suppress_update, output ready);
endinterface

// File: hdl/vpfb_out_if.sv
// Channel carrying one access result out of the frame buffer.
interface vpfb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        pixel_valid;
  logic [8:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [23:0] left_rgb;
  logic [23:0] right_rgb;

  modport source (
    output valid, read_data, pixel_valid, pixel_x, pixel_y, left_rgb, right_rgb,
    input ready
  );
  modport sink (
    input valid, read_data, pixel_valid, pixel_x, pixel_y, left_rgb, right_rgb,
    output ready
  );
endinterface

// File: hdl/vpfb_store.sv
// Byte frame store: one write port and one registered read port.
module vpfb_store #(
  parameter int unsigned DEPTH = vpfb_pkg::STORE_DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/vpfb_cdiv.sv
// Three-stage divider by a constant using a reciprocal multiply and one correction.
module vpfb_cdiv #(
  parameter int unsigned DIVISOR = 160,
  parameter int unsigned WIDTH   = vpfb_pkg::DIV_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int unsigned SHIFT = WIDTH + $clog2(DIVISOR + 1);
  localparam int unsigned RW    = SHIFT + 1;
  localparam int unsigned PW    = WIDTH + RW;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(DIVISOR);
  localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];
  localparam logic [WIDTH-1:0] DIV_W = WIDTH'(DIVISOR);

  logic [2:0]         vld_q;
  logic [PW-1:0]      prod_q;
  logic [WIDTH-1:0]   n1_q, n2_q, q2_q, qd_q;
  logic [WIDTH-1:0]   quot_q, rem_q;
  logic [WIDTH-1:0]   q_est;
  logic [2*WIDTH-1:0] qd_full;
  logic [WIDTH-1:0]   r_est;

  assign q_est   = prod_q[SHIFT +: WIDTH];
  assign qd_full = {{WIDTH{1'b0}}, q_est} * {{WIDTH{1'b0}}, DIV_W};
  assign r_est   = n2_q - qd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {{RW{1'b0}}, dividend_i} * {{WIDTH{1'b0}}, RECIP};
    n1_q   <= dividend_i;
    qd_q   <= qd_full[WIDTH-1:0];
    q2_q   <= q_est;
    n2_q   <= n1_q;
    if (r_est >= DIV_W) begin
      quot_q <= q2_q + WIDTH'(1);
      rem_q  <= r_est - DIV_W;
    end else begin
      quot_q <= q2_q;
      rem_q  <= r_est;
    end
  end

  assign done_o      = vld_q[2];
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

// File: hdl/video_port_frame_buffer_unit.sv
// Port-mapped display card: frame store, address ports, mode control and pixel reports.
//
// Each transfer on in_i is one I/O access (port write or port read); each
// produces exactly one transfer on out_o, in order. An output register
// separates the two channels, so a new access is taken while the previous
// result is being handed over.
// Address, mode and unknown-port accesses and data writes without a pixel
// report load the output register directly. A data read passes through the
// registered read port of the frame store. A reported graphics pixel write
// waits for the three-stage constant dividers that produce the pixel
// coordinates.
// After reset, and after every mode write of 0 or 1, the frame store is
// cleared one byte per cycle over max(TEXT_COLUMNS*TEXT_ROWS,
// GFX_COLUMNS*GFX_ROWS/2) bytes, 38400 with the default parameters. During
// the clear in_i is not ready; the result of the mode write is still
// delivered. When the receiver stalls out_o, the result is held and in_i
// stops accepting until the output register frees up.
module video_port_frame_buffer_unit #(
  parameter int unsigned TEXT_COLUMNS = vpfb_pkg::TEXT_COLUMNS_DEF,
  parameter int unsigned TEXT_ROWS    = vpfb_pkg::TEXT_ROWS_DEF,
  parameter int unsigned GFX_COLUMNS  = vpfb_pkg::GFX_COLUMNS_DEF,
  parameter int unsigned GFX_ROWS     = vpfb_pkg::GFX_ROWS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  vpfb_in_if.sink         in_i,
  vpfb_out_if.source      out_o
);

  localparam int unsigned MAX_SIZE  = 65536;
  localparam int unsigned TEXT_PROD = TEXT_COLUMNS * TEXT_ROWS;
  localparam int unsigned GFX_PROD  = (GFX_COLUMNS * GFX_ROWS) / 2;
  localparam int unsigned TEXT_SZ   = (TEXT_PROD > MAX_SIZE) ? MAX_SIZE : TEXT_PROD;
  localparam int unsigned GFX_SZ    = (GFX_PROD > MAX_SIZE) ? MAX_SIZE : GFX_PROD;
  localparam int unsigned DEPTH     = (TEXT_SZ > GFX_SZ) ? TEXT_SZ : GFX_SZ;
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned HALF_COLS = GFX_COLUMNS / 2;
  localparam int unsigned DW        = vpfb_pkg::DIV_WIDTH;
  localparam logic [16:0] TEXT_SIZE = 17'(TEXT_SZ);
  localparam logic [16:0] GFX_SIZE  = 17'(GFX_SZ);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_PIXEL = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [15:0]   wa_q, wa_d, ra_q, ra_d;
  logic [7:0]    scroll_q, scroll_d;
  logic          gfx_q, gfx_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          rng_q, rng_d;
  logic [7:0]    nib_q, nib_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    rd_q, rd_d;
  logic          pv_q, pv_d;
  logic [8:0]    px_q, px_d;
  logic [7:0]    py_q, py_d;
  logic [23:0]   lrgb_q, lrgb_d, rrgb_q, rrgb_d;
  logic          out_load;

  logic          in_acc;
  logic [16:0]   active;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          div_start;
  logic          div_y_done, div_x_done;
  logic [DW-1:0] y_quot, y_rem, x_quot, x_rem;

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign active     = gfx_q ? GFX_SIZE : TEXT_SIZE;

  always_comb begin
    state_d   = state_q;
    wa_d      = wa_q;
    ra_d      = ra_q;
    scroll_d  = scroll_q;
    gfx_d     = gfx_q;
    clr_d     = clr_q;
    rng_d     = rng_q;
    nib_d     = nib_q;
    out_load  = 1'b0;
    rd_d      = vpfb_pkg::NO_DATA;
    pv_d      = 1'b0;
    px_d      = '0;
    py_d      = '0;
    lrgb_d    = '0;
    rrgb_d    = '0;
    mem_we    = 1'b0;
    mem_waddr = wa_q[AW-1:0];
    mem_wdata = in_i.value;
    mem_re    = 1'b0;
    div_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == vpfb_pkg::OP_READ) begin
            if (in_i.port == vpfb_pkg::PORT_DATA) begin
              rng_d   = ({1'b0, ra_q} < active);
              mem_re  = ({1'b0, ra_q} < active);
              state_d = ST_READ;
              if (!gfx_q) begin
                ra_d = vpfb_pkg::bump(ra_q);
              end
            end else begin
              out_load = 1'b1;
            end
          end else begin
            case (in_i.port)
              vpfb_pkg::PORT_DATA: begin
                wa_d = vpfb_pkg::bump(wa_q);
                if ({1'b0, wa_q} < active) begin
                  mem_we = 1'b1;
                  if (!in_i.suppress_update && gfx_q) begin
                    div_start = 1'b1;
                    nib_d     = in_i.value;
                    state_d   = ST_PIXEL;
                  end else begin
                    out_load = 1'b1;
                  end
                end else begin
                  out_load = 1'b1;
                end
              end
              vpfb_pkg::PORT_ADDR_LO: begin
                wa_d     = {wa_q[15:8], in_i.value};
                ra_d     = {ra_q[15:8], in_i.value};
                out_load = 1'b1;
              end
              vpfb_pkg::PORT_ADDR_HI: begin
                wa_d     = {in_i.value, wa_q[7:0]};
                ra_d     = {in_i.value, ra_q[7:0]};
                out_load = 1'b1;
              end
              vpfb_pkg::PORT_MODE: begin
                out_load = 1'b1;
                if (in_i.value == vpfb_pkg::MODE_TEXT ||
                    in_i.value == vpfb_pkg::MODE_GFX) begin
                  wa_d    = '0;
                  ra_d    = '0;
                  gfx_d   = in_i.value[0];
                  clr_d   = '0;
                  state_d = ST_CLEAR;
                  if (!in_i.value[0]) begin
                    scroll_d = '0;
                  end
                end else if (in_i.value[4]) begin
                  scroll_d = {scroll_q[7:4], in_i.value[3:0]};
                end else if (in_i.value[5]) begin
                  scroll_d = {in_i.value[3:0], scroll_q[3:0]};
                end
              end
              default: begin
                out_load = 1'b1;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        out_load = 1'b1;
        rd_d     = rng_q ? mem_rdata : vpfb_pkg::NO_DATA;
        state_d  = ST_IDLE;
      end
      ST_PIXEL: begin
        if (div_y_done && div_x_done) begin
          out_load = 1'b1;
          pv_d     = 1'b1;
          px_d     = x_rem[8:0];
          py_d     = y_quot[7:0];
          lrgb_d   = vpfb_pkg::palette(nib_q[7:4]);
          rrgb_d   = vpfb_pkg::palette(nib_q[3:0]);
          state_d  = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wa_q        <= '0;
      ra_q        <= '0;
      scroll_q    <= '0;
      gfx_q       <= 1'b0;
      clr_q       <= '0;
      rng_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wa_q        <= wa_d;
      ra_q        <= ra_d;
      scroll_q    <= scroll_d;
      gfx_q       <= gfx_d;
      clr_q       <= clr_d;
      rng_q       <= rng_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nib_q <= nib_d;
    if (out_load) begin
      rd_q   <= rd_d;
      pv_q   <= pv_d;
      px_q   <= px_d;
      py_q   <= py_d;
      lrgb_q <= lrgb_d;
      rrgb_q <= rrgb_d;
    end
  end

  vpfb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (ra_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  vpfb_cdiv #(
    .DIVISOR (HALF_COLS),
    .WIDTH   (DW)
  ) u_div_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  ({1'b0, wa_q}),
    .done_o      (div_y_done),
    .quotient_o  (y_quot),
    .remainder_o (y_rem)
  );

  vpfb_cdiv #(
    .DIVISOR (GFX_COLUMNS),
    .WIDTH   (DW)
  ) u_div_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  ({wa_q, 1'b0}),
    .done_o      (div_x_done),
    .quotient_o  (x_quot),
    .remainder_o (x_rem)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = rd_q;
  assign out_o.pixel_valid = pv_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.pixel_y     = py_q;
  assign out_o.left_rgb    = lrgb_q;
  assign out_o.right_rgb   = rrgb_q;

  // The row remainder below must stay under its divisor, and the column quotient must not exceed the row quotient.
  a_div_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_y_done |-> (y_rem < DW'(HALF_COLS)) && (x_quot <= y_quot))
    else $error("pixel coordinate divider out of range");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_i.ready)
    else $error("access accepted while the frame store is being cleared");

  a_pixel_in_gfx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.pixel_valid) |-> (gfx_q && out_o.read_data == vpfb_pkg::NO_DATA))
    else $error("pixel report outside graphics mode");

  a_gfx_read_holds_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.opcode == vpfb_pkg::OP_READ && in_i.port == vpfb_pkg::PORT_DATA && gfx_q)
    |=> $stable(ra_q))
    else $error("read address moved on a graphics-mode data read");

endmodule
